// ===== rtl/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and codes for the modular square root block.
// ----------------------------------------------------------------------------
package msr_pkg;

  // Operand width of residue, modulus and roots
  localparam int WIDTH = 16;

  // Width of the multiply step counter and of the 2-adic exponent
  localparam int CW = $clog2(WIDTH + 1);

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NQR  = 2'd1;
  localparam logic [1:0] ST_NONR = 2'd2;

  typedef struct packed {
    logic [WIDTH-1:0] value_in;
    logic [WIDTH-1:0] prime;
  } in_t;

  typedef struct packed {
    logic [WIDTH-1:0] root;
    logic [WIDTH-1:0] other_root;
    logic [1:0]       status;
  } out_t;

endpackage

// ===== rtl/modular_square_root.sv =====
// ----------------------------------------------------------------------------
// modular_square_root
// Tonelli-Shanks square root modulo an odd prime, with a modulus of two answered
// directly, on one shared modular multiplier driven by a small sequencer.
// ----------------------------------------------------------------------------
// Run time: data dependent; each modular multiply steps through the multiplier
// bits MSB first, one exponentiation up to 2*WIDTH multiplies. A composite
// modulus may search every z below the modulus for a non-residue, which sets
// the worst case.
// Throughput: one item at a time; busy falls as the result is shown with done.
// Reset: synchronous, active high; sequencer idles, no strobe; receiver never stalls.
module modular_square_root (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  msr_pkg::in_t  operand,
  output logic          done,
  output msr_pkg::out_t result
);

  localparam int W  = msr_pkg::WIDTH;
  localparam int CW = msr_pkg::CW;

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_RED    = 20'h00002,
    S_EULER  = 20'h00004,
    S_FACT   = 20'h00008,
    S_NRS    = 20'h00010,
    S_GETC   = 20'h00020,
    S_GETT   = 20'h00040,
    S_GETR   = 20'h00080,
    S_LOOP   = 20'h00100,
    S_SQT    = 20'h00200,
    S_SQC    = 20'h00400,
    S_SQCR   = 20'h00800,
    S_UPC    = 20'h01000,
    S_UPT    = 20'h02000,
    S_UPR    = 20'h04000,
    S_POW    = 20'h08000,
    S_POW_SQ = 20'h10000,
    S_POW_SH = 20'h20000,
    S_MUL    = 20'h40000,
    S_SPARE  = 20'h80000
  } state_t;

  state_t state, state_next, ret, ret_next, pret, pret_next;

  logic [W-1:0] p, p_next, pm1, a, a_next;
  logic [W-1:0] q, q_next, z, z_next, c, c_next, t, t_next, r, r_next;
  logic [W-1:0] x, x_next;
  logic [CW-1:0] s, s_next, m, m_next, i, i_next, cnt, cnt_next;
  logic [W-1:0] e, e_next, base, base_next, res, res_next;
  logic [W-1:0] mx, mx_next, my, my_next, acc, acc_next;
  logic [CW-1:0] mcnt, mcnt_next;
  logic          done_next;
  msr_pkg::out_t result_next;

  // Multiplier step: double, reduce, add multiplicand if multiplier bit set, reduce
  logic [W:0] dbl, dbl_red, sum, sum_red;

  assign pm1 = p - W'(1);
  assign busy = (state != S_IDLE);

  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
    sum     = dbl_red + (mx[W-1] ? {1'b0, my} : '0);
    sum_red = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
  end

  // Sequencer
  always_comb begin
    state_next  = state;
    ret_next    = ret;
    pret_next   = pret;
    p_next      = p;
    a_next      = a;
    q_next      = q;
    z_next      = z;
    c_next      = c;
    t_next      = t;
    r_next      = r;
    x_next      = x;
    s_next      = s;
    m_next      = m;
    i_next      = i;
    cnt_next    = cnt;
    e_next      = e;
    base_next   = base;
    res_next    = res;
    mx_next     = mx;
    my_next     = my;
    acc_next    = acc;
    mcnt_next   = mcnt;
    done_next   = 1'b0;
    result_next = result;

    case (state)
      S_IDLE: begin
        if (start) begin
          p_next = operand.prime;
          if (operand.prime < W'(2)) begin
            result_next = '{root: '0, other_root: '0, status: msr_pkg::ST_NONR};
            done_next   = 1'b1;
          end else if (operand.prime == W'(2)) begin
            result_next.root       = W'(operand.value_in[0]);
            result_next.other_root = W'(operand.value_in[0]);
            result_next.status     = msr_pkg::ST_OK;
            done_next              = 1'b1;
          end else begin
            // reduce the residue: value_in * 1 mod p
            mx_next = operand.value_in; my_next = W'(1);
            acc_next = '0; mcnt_next = '0;
            ret_next = S_RED; state_next = S_MUL;
          end
        end
      end

      S_RED: begin
        a_next = acc;
        if (acc == '0) begin
          result_next = '{root: '0, other_root: '0, status: msr_pkg::ST_OK};
          done_next = 1'b1; state_next = S_IDLE;
        end else begin
          e_next = pm1 >> 1; base_next = acc; res_next = W'(1);
          pret_next = S_EULER; state_next = S_POW;
        end
      end

      S_EULER: begin
        if (res != W'(1)) begin
          result_next = '{root: '0, other_root: '0, status: msr_pkg::ST_NQR};
          done_next = 1'b1; state_next = S_IDLE;
        end else begin
          q_next = pm1; s_next = '0; state_next = S_FACT;
        end
      end

      // strip factors of two from p-1
      S_FACT: begin
        if (!q[0]) begin
          q_next = q >> 1; s_next = s + CW'(1);
        end else begin
          z_next = W'(2);
          e_next = pm1 >> 1; base_next = W'(2); res_next = W'(1);
          pret_next = S_NRS; state_next = S_POW;
        end
      end

      // search upward for a non-residue
      S_NRS: begin
        if (res == pm1) begin
          e_next = q; base_next = z; res_next = W'(1);
          pret_next = S_GETC; state_next = S_POW;
        end else if (z + W'(1) == p) begin
          result_next = '{root: '0, other_root: '0, status: msr_pkg::ST_NONR};
          done_next = 1'b1; state_next = S_IDLE;
        end else begin
          z_next = z + W'(1);
          e_next = pm1 >> 1; base_next = z + W'(1); res_next = W'(1);
          pret_next = S_NRS; state_next = S_POW;
        end
      end

      S_GETC: begin
        c_next = res;
        e_next = q; base_next = a; res_next = W'(1);
        pret_next = S_GETT; state_next = S_POW;
      end

      S_GETT: begin
        t_next = res;
        e_next = (q >> 1) + W'(1); base_next = a; res_next = W'(1);
        pret_next = S_GETR; state_next = S_POW;
      end

      S_GETR: begin
        r_next = res; m_next = s; state_next = S_LOOP;
      end

      S_LOOP: begin
        if (t == '0) begin
          result_next = '{root: '0, other_root: '0, status: msr_pkg::ST_OK};
          done_next = 1'b1; state_next = S_IDLE;
        end else if (t == W'(1)) begin
          result_next.root       = r;
          result_next.other_root = (r == '0) ? '0 : p - r;
          result_next.status     = msr_pkg::ST_OK;
          done_next = 1'b1; state_next = S_IDLE;
        end else if (m > CW'(1)) begin
          i_next = CW'(1);
          mx_next = t; my_next = t; acc_next = '0; mcnt_next = '0;
          ret_next = S_SQT; state_next = S_MUL;
        end else begin
          result_next = '{root: '0, other_root: '0, status: msr_pkg::ST_NONR};
          done_next = 1'b1; state_next = S_IDLE;
        end
      end

      // find least i with t^(2^i) == 1
      S_SQT: begin
        if (acc == W'(1)) begin
          x_next = c; cnt_next = m - i - CW'(1); state_next = S_SQC;
        end else if (i + CW'(1) < m) begin
          i_next = i + CW'(1);
          mx_next = acc; my_next = acc; acc_next = '0; mcnt_next = '0;
          ret_next = S_SQT; state_next = S_MUL;
        end else begin
          result_next = '{root: '0, other_root: '0, status: msr_pkg::ST_NONR};
          done_next = 1'b1; state_next = S_IDLE;
        end
      end

      // b = c squared m-i-1 times
      S_SQC: begin
        mx_next = x; my_next = x; acc_next = '0; mcnt_next = '0;
        state_next = S_MUL;
        if (cnt == '0) begin
          m_next = i; ret_next = S_UPC;
        end else begin
          cnt_next = cnt - CW'(1); ret_next = S_SQCR;
        end
      end

      S_SQCR: begin
        x_next = acc; state_next = S_SQC;
      end

      S_UPC: begin
        c_next = acc;
        mx_next = t; my_next = acc; acc_next = '0; mcnt_next = '0;
        ret_next = S_UPT; state_next = S_MUL;
      end

      S_UPT: begin
        t_next = acc;
        mx_next = r; my_next = x; acc_next = '0; mcnt_next = '0;
        ret_next = S_UPR; state_next = S_MUL;
      end

      S_UPR: begin
        r_next = acc; state_next = S_LOOP;
      end

      // right-to-left square and multiply
      S_POW: begin
        mx_next = base; my_next = base; acc_next = '0; mcnt_next = '0;
        state_next = S_MUL;
        if (e == '0) begin
          state_next = pret;
        end else if (e[0]) begin
          mx_next = res; ret_next = S_POW_SQ;
        end else begin
          ret_next = S_POW_SH;
        end
      end

      S_POW_SQ: begin
        res_next = acc;
        mx_next = base; my_next = base; acc_next = '0; mcnt_next = '0;
        ret_next = S_POW_SH; state_next = S_MUL;
      end

      S_POW_SH: begin
        base_next = acc; e_next = e >> 1; state_next = S_POW;
      end

      // one multiplier bit per cycle, MSB first
      S_MUL: begin
        acc_next  = sum_red[W-1:0];
        mx_next   = mx << 1;
        mcnt_next = mcnt + CW'(1);
        if (mcnt == CW'(W - 1)) state_next = ret;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ret <= ret_next;   pret <= pret_next;
    p <= p_next;       a <= a_next;       q <= q_next;     z <= z_next;
    c <= c_next;       t <= t_next;       r <= r_next;     x <= x_next;
    s <= s_next;       m <= m_next;       i <= i_next;     cnt <= cnt_next;
    e <= e_next;       base <= base_next; res <= res_next;
    mx <= mx_next;     my <= my_next;     acc <= acc_next; mcnt <= mcnt_next;
    result <= result_next;
  end

endmodule

// ===== rtl/msr_checker.sv =====
// ----------------------------------------------------------------------------
// msr_checker
// Port-level checks for the modular square root block.
// ----------------------------------------------------------------------------
module msr_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input msr_pkg::out_t result
);

  // a result only appears once the sequencer is idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  // an accepted item either starts work or finishes at once
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("item dropped");

  // status stays within its codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status != 2'd3) else $error("bad status");

  // failure results carry zero roots
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != msr_pkg::ST_OK |-> result.root == '0 &&
    result.other_root == '0) else $error("roots on failure");

endmodule

bind modular_square_root msr_checker u_msr_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
